// File: rtl/sc1a_pkg.sv
package sc1a_pkg;

  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_E1   = 2'd1,
    PFX_E0   = 2'd2,
    PFX_SKIP = 2'd3
  } prefix_t;

  localparam logic [7:0] SC_E1       = 8'he1;
  localparam logic [7:0] SC_E0       = 8'he0;
  localparam logic [7:0] SC_CTRL_MK  = 8'h1d;
  localparam logic [7:0] SC_CTRL_BRK = 8'h9d;
  localparam logic [7:0] SC_LSH_MK   = 8'h2a;
  localparam logic [7:0] SC_RSH_MK   = 8'h36;
  localparam logic [7:0] SC_LSH_BRK  = 8'haa;
  localparam logic [7:0] SC_RSH_BRK  = 8'hb6;
  localparam logic [7:0] SC_LEFT     = 8'h4b;
  localparam logic [7:0] SC_RIGHT    = 8'h4d;
  localparam logic [7:0] KEY_LEFT    = 8'd55;
  localparam logic [7:0] KEY_RIGHT   = 8'd56;
  localparam logic [7:0] KEY_COLS    = 8'd58;
  localparam logic [7:0] ENTRY_MIN   = 8'h80;

  // row = {shift, ctrl}
  localparam logic [7:0] KEY_MAP [4][58] = '{
    '{8'h00,
      8'h9b, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9,
      8'hb0, 8'had, 8'hba, 8'h00, 8'h00, 8'hd1, 8'hd7, 8'hc5, 8'hd2, 8'hd4,
      8'hd9, 8'hd5, 8'hc9, 8'hcf, 8'hd0, 8'h00, 8'h00, 8'h8d, 8'h00, 8'hc1,
      8'hd3, 8'hc4, 8'hc6, 8'hc7, 8'hc8, 8'hca, 8'hcb, 8'hcc, 8'hbb, 8'h00,
      8'h00, 8'h00, 8'h00, 8'hda, 8'hd8, 8'hc3, 8'hd6, 8'hc2, 8'hce, 8'hcd,
      8'hac, 8'hae, 8'haf, 8'h00, 8'h88, 8'h95, 8'ha0},
    '{8'h00,
      8'h9b, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9,
      8'hb0, 8'had, 8'hba, 8'h00, 8'h00, 8'h91, 8'h97, 8'h85, 8'h92, 8'h94,
      8'h99, 8'h95, 8'h89, 8'h8f, 8'h90, 8'h00, 8'h00, 8'h8d, 8'h00, 8'h81,
      8'h93, 8'h84, 8'h86, 8'h87, 8'h88, 8'h8a, 8'h8b, 8'h8c, 8'hbb, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h9a, 8'h98, 8'h83, 8'h96, 8'h82, 8'h8e, 8'h8d,
      8'hac, 8'hae, 8'haf, 8'h00, 8'h88, 8'h95, 8'ha0},
    '{8'h00,
      8'h9b, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9,
      8'hb0, 8'hbd, 8'haa, 8'h00, 8'h00, 8'hd1, 8'hd7, 8'hc5, 8'hd2, 8'hd4,
      8'hd9, 8'hd5, 8'hc9, 8'hcf, 8'hc0, 8'h00, 8'h00, 8'h8d, 8'h00, 8'hc1,
      8'hd3, 8'hc4, 8'hc6, 8'hc7, 8'hc8, 8'hca, 8'hcb, 8'hcc, 8'hab, 8'h00,
      8'h00, 8'h00, 8'h00, 8'hda, 8'hd8, 8'hc3, 8'hd6, 8'hc2, 8'hde, 8'hdd,
      8'hbc, 8'hbe, 8'hbf, 8'h00, 8'h88, 8'h95, 8'ha0},
    '{8'h00,
      8'h9b, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9,
      8'hb0, 8'hbd, 8'haa, 8'h00, 8'h00, 8'h91, 8'h97, 8'h85, 8'h92, 8'h94,
      8'h99, 8'h95, 8'h89, 8'h8f, 8'h80, 8'h00, 8'h00, 8'h8d, 8'h00, 8'h81,
      8'h93, 8'h84, 8'h86, 8'h87, 8'h88, 8'h8a, 8'h8b, 8'h8c, 8'hab, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h9a, 8'h98, 8'h83, 8'h96, 8'h82, 8'h9e, 8'h94,
      8'hbc, 8'hbe, 8'hbf, 8'h00, 8'h88, 8'h95, 8'ha0}
  };

endpackage

// File: rtl/scan_code_set1_to_ascii_keys.sv
// Latency: a key code is valid the cycle after its scan byte transfers.
// Throughput: one scan byte per cycle; the output register holds one result
// and input stalls only while that result waits and out_ready is low.
// Reset (rst, synchronous): no prefix pending, Shift and Ctrl released,
// output empty.
module scan_code_set1_to_ascii_keys (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] key_code
);
  import sc1a_pkg::*;

  prefix_t    prefix, prefix_next;
  logic       shift_down, shift_down_next;
  logic       ctrl_down, ctrl_down_next;
  logic       plain;
  logic [7:0] code;
  logic [7:0] entry;
  logic       hit;
  logic       accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    prefix_next = prefix;
    plain       = 1'b0;
    code        = scan_byte;
    unique case (prefix)
      PFX_E1: begin
        if (scan_byte == SC_CTRL_MK || scan_byte == SC_CTRL_BRK) begin
          prefix_next = PFX_SKIP;
        end else if (scan_byte == SC_E0) begin
          prefix_next = PFX_E0;
        end else begin
          prefix_next = PFX_NONE;
          plain       = (scan_byte != SC_E1);
        end
      end
      PFX_E0: begin
        prefix_next = PFX_NONE;
        if (scan_byte == SC_CTRL_MK || scan_byte == SC_CTRL_BRK) begin
          plain = 1'b1;
        end else if (scan_byte == SC_LEFT) begin
          plain = 1'b1;
          code  = KEY_LEFT;
        end else if (scan_byte == SC_RIGHT) begin
          plain = 1'b1;
          code  = KEY_RIGHT;
        end
      end
      PFX_SKIP: begin
        prefix_next = PFX_NONE;
      end
      PFX_NONE: begin
        if (scan_byte == SC_E1) begin
          prefix_next = PFX_E1;
        end else if (scan_byte == SC_E0) begin
          prefix_next = PFX_E0;
        end else begin
          plain = 1'b1;
        end
      end
      default: begin
        prefix_next = PFX_NONE;
      end
    endcase
  end

  // plain code: modifiers, dropped codes, then table lookup on current flags
  always_comb begin
    shift_down_next = shift_down;
    ctrl_down_next  = ctrl_down;
    hit             = 1'b0;
    entry           = KEY_MAP[{shift_down, ctrl_down}][code[5:0]];
    if (plain) begin
      priority if (code == SC_CTRL_MK) begin
        ctrl_down_next = 1'b1;
      end else if (code == SC_CTRL_BRK) begin
        ctrl_down_next = 1'b0;
      end else if (code == SC_LSH_MK || code == SC_RSH_MK) begin
        shift_down_next = 1'b1;
      end else if (code == SC_LSH_BRK || code == SC_RSH_BRK) begin
        shift_down_next = 1'b0;
      end else if (code < KEY_COLS) begin
        // dropped codes hold 0 (or 8'h80) in the table, so the strict compare rejects them
        hit = (entry > ENTRY_MIN);
      end else begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix     <= PFX_NONE;
      shift_down <= 1'b0;
      ctrl_down  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        prefix     <= prefix_next;
        shift_down <= shift_down_next;
        ctrl_down  <= ctrl_down_next;
        out_valid  <= hit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      key_code <= entry[6:0];
    end
  end

endmodule
